@@ hw/rtl/bsd_pkg.sv @@
// Shared types and constants for the bitonic subsequence deletions block.
// Holds beat formats, inter-cell token formats and the chain control group.
// No dependencies.
`default_nettype none
package bsd_pkg;

    localparam int MAX_LEN = 1024;
    localparam int VAL_W   = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W   = LEN_W + 1;
    localparam int DEL_W   = 11;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_item;
    } t_in_beat;

    typedef struct packed {
        logic [DEL_W-1:0] deletions;
        logic             too_long;
    } t_out_beat;

    typedef struct packed {
        logic                    valid;
        logic                    adj;
        logic signed [VAL_W-1:0] v;
        logic [LEN_W-1:0]        len;
    } t_rtok;

    typedef struct packed {
        logic                    valid;
        logic                    adj;
        logic                    head;
        logic signed [VAL_W-1:0] v;
        logic [LEN_W-1:0]        len;
        logic [SUM_W-1:0]        best;
    } t_ftok;

    typedef struct packed {
        logic shift;
        logic go;
        logic clr;
    } t_ctrl;

endpackage
`default_nettype wire

@@ hw/rtl/bsd_cell.sv @@
// One cell of the chain: holds one element with its rise and fall lengths.
// Passes rise tokens rightward and fall tokens leftward. Uses bsd_pkg.
`default_nettype none
module bsd_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  bsd_pkg::t_ctrl                   i_ctrl,
    input  wire  signed [bsd_pkg::VAL_W-1:0] i_shift_v,
    input  wire                              i_shift_act,
    input  wire                              i_prev_act,
    input  wire                              i_next_act,
    input  bsd_pkg::t_rtok                   i_rtok,
    input  bsd_pkg::t_ftok                   i_ftok,
    output logic                             o_act,
    output logic signed [bsd_pkg::VAL_W-1:0] o_v,
    output bsd_pkg::t_rtok                   o_rtok,
    output bsd_pkg::t_ftok                   o_ftok
);
    import bsd_pkg::*;

    logic                    r_act, n_act;
    logic                    r_rdone, n_rdone;
    logic                    r_rpend, n_rpend;
    logic                    r_fdone, n_fdone;
    logic                    r_fpend, n_fpend;
    logic signed [VAL_W-1:0] r_v, n_v;
    logic [LEN_W-1:0]        r_rlen, n_rlen;
    logic [LEN_W-1:0]        r_flen, n_flen;
    logic [SUM_W-1:0]        r_fbest, n_fbest;
    t_rtok                   r_rtok, n_rtok;
    t_ftok                   r_ftok, n_ftok;

    logic                    first, last;
    logic [LEN_W-1:0]        rcand, fcand;
    logic [SUM_W-1:0]        sum;

    assign first = r_act & ~i_prev_act;
    assign last  = r_act & ~i_next_act;
    assign rcand = i_rtok.len + LEN_W'(1);
    assign fcand = i_ftok.len + LEN_W'(1);
    assign sum   = {1'b0, r_rlen} + {1'b0, r_flen};

    always_comb begin
        n_act   = r_act;
        n_rdone = r_rdone;
        n_rpend = r_rpend;
        n_fdone = r_fdone;
        n_fpend = r_fpend;
        n_v     = r_v;
        n_rlen  = r_rlen;
        n_flen  = r_flen;
        n_fbest = r_fbest;
        n_rtok  = r_rtok;
        n_ftok  = r_ftok;
        if (i_ctrl.shift) begin
            n_act  = i_shift_act;
            n_v    = i_shift_v;
            n_rlen = LEN_W'(1);
            n_flen = LEN_W'(1);
        end else begin
            if (r_act && !r_rdone) begin
                if (i_rtok.valid && ($signed(i_rtok.v) < $signed(r_v)) && (rcand > r_rlen)) begin
                    n_rlen = rcand;
                end
                if ((i_rtok.valid && i_rtok.adj) || (i_ctrl.go && first)) begin
                    n_rdone = 1'b1;
                    n_rpend = 1'b1;
                end
            end
            if (i_rtok.valid) begin
                n_rtok     = i_rtok;
                n_rtok.adj = 1'b0;
            end else if (r_rpend) begin
                n_rtok.valid = 1'b1;
                n_rtok.adj   = 1'b1;
                n_rtok.v     = r_v;
                n_rtok.len   = r_rlen;
                n_rpend      = 1'b0;
            end else begin
                n_rtok.valid = 1'b0;
            end

            if (r_act && !r_fdone) begin
                if (i_ftok.valid && ($signed(i_ftok.v) < $signed(r_v)) && (fcand > r_flen)) begin
                    n_flen = fcand;
                end
                if (i_ftok.valid && i_ftok.adj) begin
                    n_fdone = 1'b1;
                    n_fpend = 1'b1;
                    n_fbest = i_ftok.best;
                end else if (last && r_rdone) begin
                    n_fdone = 1'b1;
                    n_fpend = 1'b1;
                    n_fbest = '0;
                end
            end
            if (i_ftok.valid) begin
                n_ftok     = i_ftok;
                n_ftok.adj = 1'b0;
            end else if (r_fpend) begin
                n_ftok.valid = 1'b1;
                n_ftok.adj   = 1'b1;
                n_ftok.head  = first;
                n_ftok.v     = r_v;
                n_ftok.len   = r_flen;
                n_ftok.best  = (sum > r_fbest) ? sum : r_fbest;
                n_fpend      = 1'b0;
            end else begin
                n_ftok.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_rlen      <= n_rlen;
        r_flen      <= n_flen;
        r_fbest     <= n_fbest;
        r_rtok.adj  <= n_rtok.adj;
        r_rtok.v    <= n_rtok.v;
        r_rtok.len  <= n_rtok.len;
        r_ftok.adj  <= n_ftok.adj;
        r_ftok.head <= n_ftok.head;
        r_ftok.v    <= n_ftok.v;
        r_ftok.len  <= n_ftok.len;
        r_ftok.best <= n_ftok.best;
        if (!i_rst_n || i_ctrl.clr) begin
            r_act        <= 1'b0;
            r_rdone      <= 1'b0;
            r_rpend      <= 1'b0;
            r_fdone      <= 1'b0;
            r_fpend      <= 1'b0;
            r_rtok.valid <= 1'b0;
            r_ftok.valid <= 1'b0;
        end else begin
            r_act        <= n_act;
            r_rdone      <= n_rdone;
            r_rpend      <= n_rpend;
            r_fdone      <= n_fdone;
            r_fpend      <= n_fpend;
            r_rtok.valid <= n_rtok.valid;
            r_ftok.valid <= n_ftok.valid;
        end
    end

    assign o_act  = r_act;
    assign o_v    = r_v;
    assign o_rtok = r_rtok;
    assign o_ftok = r_ftok;

endmodule
`default_nettype wire

@@ hw/rtl/bsd_chain.sv @@
// Row of MAX_LEN bsd_cell instances linked neighbor to neighbor.
// Elements shift in at the right end; fall tokens leave at the left end. Uses bsd_pkg.
`default_nettype none
module bsd_chain (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  bsd_pkg::t_ctrl                   i_ctrl,
    input  wire  signed [bsd_pkg::VAL_W-1:0] i_value,
    output bsd_pkg::t_ftok                   o_ftok
);
    import bsd_pkg::*;

    logic                    act   [MAX_LEN];
    logic signed [VAL_W-1:0] val   [MAX_LEN];
    t_rtok                   rlink [MAX_LEN];
    t_ftok                   flink [MAX_LEN];

    genvar k;
    generate
        for (k = 0; k < MAX_LEN; k++) begin : g_cell
            logic                    shift_act, prev_act, next_act;
            logic signed [VAL_W-1:0] shift_v;
            t_rtok                   rin;
            t_ftok                   fin;

            if (k == 0) begin : g_left
                assign prev_act = 1'b0;
                assign rin      = '0;
            end else begin : g_inner_l
                assign prev_act = act[k-1];
                assign rin      = rlink[k-1];
            end

            if (k == MAX_LEN - 1) begin : g_right
                assign next_act  = 1'b0;
                assign fin       = '0;
                assign shift_act = 1'b1;
                assign shift_v   = i_value;
            end else begin : g_inner_r
                assign next_act  = act[k+1];
                assign fin       = flink[k+1];
                assign shift_act = act[k+1];
                assign shift_v   = val[k+1];
            end

            bsd_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (i_ctrl),
                .i_shift_v   (shift_v),
                .i_shift_act (shift_act),
                .i_prev_act  (prev_act),
                .i_next_act  (next_act),
                .i_rtok      (rin),
                .i_ftok      (fin),
                .o_act       (act[k]),
                .o_v         (val[k]),
                .o_rtok      (rlink[k]),
                .o_ftok      (flink[k])
            );
        end
    endgenerate

    assign o_ftok = flink[0];

endmodule
`default_nettype wire

@@ hw/rtl/bitonic_subsequence_deletions.sv @@
// Minimum deletions to a strictly bitonic sequence, top level.
// Instantiates bsd_chain (row of bsd_cell); uses bsd_pkg.
//
// Input channel: one element per beat (value, last_item). Elements enter a row
// of MAX_LEN cells from the right; beyond MAX_LEN they are dropped and too_long
// is raised for the current sequence. The beat with last_item closes it.
// Output channel: one beat (deletions, too_long) per closed sequence.
// Loading takes one element per cycle while the input is not stalled. After
// the closing beat, rise tokens ripple right and fall tokens ripple left
// through the cells, then the final token walks out of the left end of the
// row. Input stall is high from the closing beat until the result beat has
// been taken and the row cleared. A stalled result holds in its register.
// Synchronous active-low reset empties the row and drops any partly loaded
// sequence.
`default_nettype none
module bitonic_subsequence_deletions (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  bsd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output bsd_pkg::t_out_beat o_out_data
);
    import bsd_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_RUN,
        S_SEND
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_count;
    logic             r_ovf;
    logic             r_go;
    logic             r_clr;
    logic             r_out_valid;
    t_out_beat        r_out_data;

    logic             in_acc;
    logic             room;
    t_ctrl            ctrl;
    t_ftok            ftok;
    logic [SUM_W-1:0] del_full;

    assign o_in_stall = (r_state != S_LOAD) | r_clr;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign room       = (r_count < LEN_W'(MAX_LEN));
    assign ctrl.shift = in_acc & room;
    assign ctrl.go    = r_go;
    assign ctrl.clr   = r_clr;
    assign del_full   = {1'b0, r_count} + SUM_W'(1) - ftok.best;

    bsd_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_value (i_in_data.value),
        .o_ftok  (ftok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_go        <= 1'b0;
            r_clr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go  <= 1'b0;
            r_clr <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (room) begin
                            r_count <= r_count + LEN_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last_item) begin
                            r_go    <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (ftok.valid && ftok.head) begin
                        r_out_data.deletions <= DEL_W'(del_full);
                        r_out_data.too_long  <= r_ovf;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_clr       <= 1'b1;
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for bitonic_subsequence_deletions: drives element beats,
// predicts the fewest deletions per closed sequence and checks every result beat.
// Depends on bsd_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsd_pkg::*;

    localparam int RANDOM_ITEMS  = 500;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 5 * MAX_LEN + 16;

    typedef enum int {
        SHAPE_BITONIC,
        SHAPE_NARROW,
        SHAPE_WIDE,
        SHAPE_EXTREME,
        SHAPE_FLAT
    } t_shape;

    class deletion_checker;
        logic signed [VAL_W-1:0] stored[$];
        bit                      spilled;
        t_out_beat               awaited[$];
        int                      elements;
        int                      closed;
        int                      spilled_runs;
        int                      checked;
        int                      errors;

        function int fewest_deletions();
            int n;
            int best;
            int longest;
            int rise[];
            int fall[];
            n = stored.size();
            rise = new[n];
            fall = new[n];
            for (int i = 0; i < n; i++) begin
                longest = 0;
                for (int j = 0; j < i; j++)
                    if (stored[j] < stored[i] && rise[j] > longest) longest = rise[j];
                rise[i] = longest + 1;
            end
            for (int i = n - 1; i >= 0; i--) begin
                longest = 0;
                for (int j = i + 1; j < n; j++)
                    if (stored[j] < stored[i] && fall[j] > longest) longest = fall[j];
                fall[i] = longest + 1;
            end
            best = 0;
            for (int i = 0; i < n; i++)
                if (rise[i] + fall[i] > best) best = rise[i] + fall[i];
            return n + 1 - best;
        endfunction

        function void take_element(t_in_beat beat);
            t_out_beat tally;
            elements++;
            if (stored.size() < MAX_LEN) stored = {stored, beat.value};
            else spilled = 1'b1;
            if (beat.last_item) begin
                tally.deletions = DEL_W'(fewest_deletions());
                tally.too_long  = spilled;
                awaited = {awaited, tally};
                closed++;
                if (spilled) spilled_runs++;
                stored.delete();
                spilled = 1'b0;
            end
        endfunction

        function void check_tally(t_out_beat got);
            t_out_beat want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got deletions %0d too_long %0b",
                         $time, got.deletions, got.too_long);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.deletions !== want.deletions) begin
                errors++;
                $display("%0t: deletions expected %0d, got %0d",
                         $time, want.deletions, got.deletions);
            end
            if (got.too_long !== want.too_long) begin
                errors++;
                $display("%0t: too_long expected %0b, got %0b",
                         $time, want.too_long, got.too_long);
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    deletion_checker chk;
    bit              steady_tx;

    bitonic_subsequence_deletions DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_element(input logic signed [VAL_W-1:0] value, input bit closes);
        int       gap;
        t_in_beat beat;
        beat.value     = value;
        beat.last_item = closes;
        gap = steady_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        chk.take_element(beat);
    endtask

    task automatic send_list(input logic signed [VAL_W-1:0] values[$]);
        steady_tx = ($urandom_range(0, 1) == 0);
        foreach (values[i]) send_element(values[i], i == values.size() - 1);
    endtask

    task automatic send_run(input int len, input t_shape shape);
        int                      peak;
        int                      step;
        int                      base;
        logic signed [VAL_W-1:0] value;
        steady_tx = ($urandom_range(0, 3) == 0);
        peak = $urandom_range(0, len - 1);
        step = $urandom_range(1, 5);
        base = int'($urandom);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_BITONIC: begin
                    value = base + step * ((i <= peak) ? i : 2 * peak - i);
                    if ($urandom_range(0, 4) == 0) value = value + int'($urandom_range(0, 6)) - 3;
                end
                SHAPE_NARROW: value = int'($urandom_range(0, 8)) - 4;
                SHAPE_WIDE:   value = $urandom;
                SHAPE_EXTREME: begin
                    case ($urandom_range(0, 6))
                        0:       value = 32'sh8000_0000;
                        1:       value = 32'sh7fff_ffff;
                        2:       value = 32'sh0000_0000;
                        3:       value = 32'shffff_ffff;
                        4:       value = 32'sh0000_0001;
                        5:       value = 32'sh8000_0001;
                        default: value = 32'sh7fff_fffe;
                    endcase
                end
                default: value = base;
            endcase
            send_element(value, i == len - 1);
        end
    endtask

    task automatic take_results();
        int hold;
        bit steady_rx;
        hold      = -1;
        steady_rx = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                chk.check_tally(o_out_data);
                steady_rx = ($urandom_range(0, 3) == 0);
                hold = -1;
                i_out_stall <= steady_rx ? 1'b0 : ($urandom_range(0, 1) == 1);
            end else if (o_out_valid === 1'b1) begin
                if (hold < 0) hold = $urandom_range(0, MAX_GAP);
                if (hold > 0) hold--;
                i_out_stall <= (hold > 0);
            end else begin
                hold = -1;
                i_out_stall <= steady_rx ? 1'b0 : ($urandom_range(0, 1) == 1);
            end
        end
    endtask

    initial begin
        logic signed [VAL_W-1:0] picks[$];
        int                      sent;
        int                      len;
        int                      roll;
        t_shape                  shape;
        chk = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none

        picks = '{32'sh8000_0000};
        send_list(picks);
        picks = '{32'sh7fff_ffff};
        send_list(picks);
        picks = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000};
        send_list(picks);
        picks = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1};
        send_list(picks);
        picks = '{32'sd9, 32'sd4, 32'sd0, -32'sd3};
        send_list(picks);
        picks = '{32'sd7, 32'sd7, 32'sd7};
        send_list(picks);
        picks = '{32'sd3, 32'sd1, 32'sd3};
        send_list(picks);

        // fill the store exactly, then overrun it
        send_run(MAX_LEN, SHAPE_FLAT);
        send_run(MAX_LEN + $urandom_range(1, 5), SHAPE_NARROW);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            roll = $urandom_range(0, 9);
            shape = (roll < 5) ? SHAPE_BITONIC :
                    (roll < 7) ? SHAPE_NARROW  :
                    (roll < 9) ? SHAPE_WIDE    : SHAPE_EXTREME;
            send_run(len, shape);
            sent += len;
        end
        i_in_valid <= 1'b0;

        while (chk.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d elements in %0d sequences (%0d overran the store).",
                 chk.elements, chk.closed, chk.spilled_runs);
        $display("Checked %0d results, %0d mismatches.", chk.checked, chk.errors);
        if (chk.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding.", chk.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bsd_pkg.sv
hw/rtl/bsd_cell.sv
hw/rtl/bsd_chain.sv
hw/rtl/bitonic_subsequence_deletions.sv
sim/tb.sv
